// ----- hdl/bcc_pkg.sv -----
// Shared types and constants for the blit clip calculator.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package bcc_pkg;

    localparam int FIELD_W   = 16;
    localparam int OFFSET_W  = 32;
    localparam int CALC_W    = 19;   // signed headroom for 16-bit sums and differences
    localparam int CFG_IDX_W = 8;

    localparam int S_TDATA_W = 8 * FIELD_W;
    localparam int M_TDATA_W = 2 * OFFSET_W + 8 * FIELD_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 8'd1;

    typedef struct packed {
        logic [FIELD_W-1:0] canvas_width;
        logic [FIELD_W-1:0] canvas_height;
    } bcc_cfg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] area_x;
        logic [FIELD_W-1:0] area_y;
        logic [FIELD_W-1:0] area_width;
        logic [FIELD_W-1:0] area_height;
        logic [FIELD_W-1:0] image_x;
        logic [FIELD_W-1:0] image_y;
        logic [FIELD_W-1:0] image_width;
        logic [FIELD_W-1:0] image_height;
    } bcc_req_t;

    typedef struct packed {
        logic                valid_res;
        logic [OFFSET_W-1:0] source_offset;
        logic [OFFSET_W-1:0] dest_offset;
        logic [FIELD_W-1:0]  clipped_area_x;
        logic [FIELD_W-1:0]  clipped_area_y;
        logic [FIELD_W-1:0]  clipped_area_width;
        logic [FIELD_W-1:0]  clipped_area_height;
        logic [FIELD_W-1:0]  clipped_image_x;
        logic [FIELD_W-1:0]  clipped_image_y;
        logic [FIELD_W-1:0]  clipped_image_width;
        logic [FIELD_W-1:0]  clipped_image_height;
    } bcc_res_t;

endpackage

`default_nettype wire

// ----- hdl/bcc_cfg_regs.sv -----
// Canvas size registers written through the configuration channel.
// Depends on bcc_pkg.
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_en,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [bcc_pkg::FIELD_W-1:0]    wr_data,
    output bcc_pkg::bcc_cfg_t                   cfg
);

    bcc_pkg::bcc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (wr_index)
                bcc_pkg::REG_CANVAS_WIDTH: begin
                    cfg_reg.canvas_width <= wr_data;
                end
                bcc_pkg::REG_CANVAS_HEIGHT: begin
                    cfg_reg.canvas_height <= wr_data;
                end
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/bcc_clip_core.sv -----
// Combinational clipping of one blit request against the canvas and work area.
// Depends on bcc_pkg.
`default_nettype none

module bcc_clip_core (
    input  wire bcc_pkg::bcc_cfg_t req_cfg,
    input  wire bcc_pkg::bcc_req_t req,
    output bcc_pkg::bcc_res_t      res
);

    localparam int W  = bcc_pkg::CALC_W;
    localparam int FW = bcc_pkg::FIELD_W;
    localparam int OW = bcc_pkg::OFFSET_W;

    function automatic logic signed [W-1:0] sx(input logic [FW-1:0] v);
        sx = {{(W-FW){v[FW-1]}}, v};
    endfunction

    function automatic logic signed [W-1:0] ux(input logic [FW-1:0] v);
        ux = {{(W-FW){1'b0}}, v};
    endfunction

    logic signed [W-1:0] ax, ay, aw, ah, bx, by, bw, bh, cw, ch;
    logic                reject;

    logic signed [W-1:0] ax1, aw1, aw2, aw3, dx, bx1, bw1, bw2;
    logic signed [W-1:0] ay1, ah1, ah2, ah3, dy, by1, bh1, bh2;
    logic signed [W-1:0] imx_diff, imy_diff, t0, t1, t2, t3, t4, t5, t6, t7;
    logic                left, top, over_x, over_y;
    logic [FW-1:0]       imx, imy;
    logic [OW-1:0]       src_x, dst_x, src_y, dst_y;
    logic [OW-1:0]       prod_src;

    always_comb begin
        ax = sx(req.area_x);
        ay = sx(req.area_y);
        aw = ux(req.area_width);
        ah = ux(req.area_height);
        bx = sx(req.image_x);
        by = sx(req.image_y);
        bw = ux(req.image_width);
        bh = ux(req.image_height);
        cw = ux(req_cfg.canvas_width);
        ch = ux(req_cfg.canvas_height);

        reject = (ax > cw) || (ay > ch) || (bx + bw < ax) || (by + bh < ay)
              || (ax + aw < bx) || (ay + ah < by);

        // x axis: work area to canvas, then bitmap to work area
        t0  = aw + ax;
        ax1 = (ax < 0) ? '0 : ax;
        aw1 = (ax < 0) ? ux(t0[FW-1:0]) : aw;
        t1  = cw - ax1;
        aw2 = (ax1 + aw1 > cw) ? ux(t1[FW-1:0]) : aw1;
        left     = bx < ax1;
        dx       = ax1 - bx;
        t2       = bw - dx;
        imx_diff = bx - ax1;
        bw1 = left ? ux(t2[FW-1:0]) : bw;
        bx1 = left ? ax1 : bx;
        imx = left ? req.image_x : imx_diff[FW-1:0];
        // dx is positive when left, bx non-negative otherwise
        src_x = left ? OW'(dx[W-2:0]) : '0;
        dst_x = left ? '0 : OW'(bx[FW-1:0]);
        over_x = (bx1 + bw1) > (ax1 + aw2);
        t3  = ax1 + aw2 - bx1;
        bw2 = over_x ? ux(t3[FW-1:0]) : bw1;
        t3  = bx1 + bw1 - ax1;
        aw3 = over_x ? aw2 : ux(t3[FW-1:0]);

        // y axis, same rule
        t4  = ah + ay;
        ay1 = (ay < 0) ? '0 : ay;
        ah1 = (ay < 0) ? ux(t4[FW-1:0]) : ah;
        t5  = ch - ay1;
        ah2 = (ay1 + ah1 > ch) ? ux(t5[FW-1:0]) : ah1;
        top      = by < ay1;
        dy       = ay1 - by;
        t6       = bh - dy;
        imy_diff = by - ay1;
        bh1 = top ? ux(t6[FW-1:0]) : bh;
        by1 = top ? ay1 : by;
        imy = top ? req.image_y : imy_diff[FW-1:0];
        // dy is at most 65535 when top, so 16 by 16 bits covers the product
        prod_src = OW'(dy[FW-1:0]) * OW'(req.image_width);
        src_y = top ? prod_src : '0;
        dst_y = top ? '0 : OW'(req_cfg.canvas_width) * OW'(by[FW-1:0]);
        over_y = (by1 + bh1) > (ay1 + ah2);
        t7  = ay1 + ah2 - by1;
        bh2 = over_y ? ux(t7[FW-1:0]) : bh1;
        t7  = by1 + bh1 - ay1;
        ah3 = over_y ? ah2 : ux(t7[FW-1:0]);

        if (reject) begin
            res.valid_res            = 1'b0;
            res.source_offset        = '0;
            res.dest_offset          = '0;
            res.clipped_area_x       = req.area_x;
            res.clipped_area_y       = req.area_y;
            res.clipped_area_width   = req.area_width;
            res.clipped_area_height  = req.area_height;
            res.clipped_image_x      = req.image_x;
            res.clipped_image_y      = req.image_y;
            res.clipped_image_width  = req.image_width;
            res.clipped_image_height = req.image_height;
        end else begin
            res.valid_res            = 1'b1;
            res.source_offset        = src_x + src_y;
            res.dest_offset          = dst_x + dst_y;
            res.clipped_area_x       = ax1[FW-1:0];
            res.clipped_area_y       = ay1[FW-1:0];
            res.clipped_area_width   = aw3[FW-1:0];
            res.clipped_area_height  = ah3[FW-1:0];
            res.clipped_image_x      = imx;
            res.clipped_image_y      = imy;
            res.clipped_image_width  = bw2[FW-1:0];
            res.clipped_image_height = bh2[FW-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/blit_clip_calculator_unit.sv -----
// Blit clip calculator: top level with stream channels and pipeline registers.
// Depends on bcc_pkg, bcc_cfg_regs and bcc_clip_core.
//
// Usage:
//   s_* channel: one blit request per item (work area and bitmap rectangle).
//   m_* channel: one result per request; m_tuser is the valid flag, clear on
//   an early reject, m_tdata holds offsets and the clipped rectangles.
//   cfg_* channel: canvas width (index 0) and height (index 1); always ready,
//   other indexes are dropped. Write only while no request is in flight.
// Path: a request accepted on s_* passes the input register, the clip logic and the
// result register before its result is offered on m_*.
// Throughput: one item per cycle while m_tready stays high, set by the single pass
// through the clip logic with its two multipliers.
// Reset (aresetn low, synchronous) empties both registers and clears the
// canvas size to zero. When m_tready is low the result holds and the input
// register still takes one more item; beyond that s_tready drops.
`default_nettype none

module blit_clip_calculator_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request channel
    input  wire logic                            s_tvalid,
    output wire logic                            s_tready,
    // lowest bit up: area_x, area_y, area_width, area_height,
    // image_x, image_y, image_width, image_height
    input  wire logic [bcc_pkg::S_TDATA_W-1:0]   s_tdata,
    // result channel
    output wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // lowest bit up: source_offset, dest_offset, clipped_area_x, clipped_area_y,
    // clipped_area_width, clipped_area_height, clipped_image_x, clipped_image_y,
    // clipped_image_width, clipped_image_height
    output wire logic [bcc_pkg::M_TDATA_W-1:0]   m_tdata,
    // valid_res
    output wire logic                            m_tuser,
    // configuration channel
    input  wire logic                            cfg_valid,
    output wire logic                            cfg_ready,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bcc_pkg::FIELD_W-1:0]     cfg_data
);

    localparam int FW = bcc_pkg::FIELD_W;

    bcc_pkg::bcc_cfg_t cfg;
    bcc_pkg::bcc_req_t req_in, req_reg;
    bcc_pkg::bcc_res_t res_comb, res_reg;
    logic              in_valid_reg, out_valid_reg;
    logic              out_advance, in_take;

    assign cfg_ready = 1'b1;

    bcc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_comb begin
        req_in.area_x       = s_tdata[0*FW +: FW];
        req_in.area_y       = s_tdata[1*FW +: FW];
        req_in.area_width   = s_tdata[2*FW +: FW];
        req_in.area_height  = s_tdata[3*FW +: FW];
        req_in.image_x      = s_tdata[4*FW +: FW];
        req_in.image_y      = s_tdata[5*FW +: FW];
        req_in.image_width  = s_tdata[6*FW +: FW];
        req_in.image_height = s_tdata[7*FW +: FW];
    end

    bcc_clip_core u_core (
        .req_cfg (cfg),
        .req     (req_reg),
        .res     (res_comb)
    );

    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            req_reg <= req_in;
        end
        if (out_advance && in_valid_reg) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.valid_res;
    assign m_tdata  = {res_reg.clipped_image_height, res_reg.clipped_image_width,
                       res_reg.clipped_image_y, res_reg.clipped_image_x,
                       res_reg.clipped_area_height, res_reg.clipped_area_width,
                       res_reg.clipped_area_y, res_reg.clipped_area_x,
                       res_reg.dest_offset, res_reg.source_offset};

endmodule

`default_nettype wire

// ----- bench/blit_clip_calculator_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for blit_clip_calculator_unit: clip prediction, stream driver and monitor.
// Depends on bcc_pkg and the blit_clip_calculator_unit RTL.

module blit_clip_calculator_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 200;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bcc_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bcc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bcc_pkg::FIELD_W-1:0]     cfg_data = '0;

    // canvas size as the block should hold it
    logic [bcc_pkg::FIELD_W-1:0] canvas_w = '0;
    logic [bcc_pkg::FIELD_W-1:0] canvas_h = '0;

    bcc_pkg::bcc_req_t blit_queue[$];
    bcc_pkg::bcc_res_t awaited_clips[$];
    bcc_pkg::bcc_req_t held_req;
    bcc_pkg::bcc_res_t want_clip;

    int idle_pct = 9;
    int errors = 0;
    int cycles = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_drawn = 0;
    int n_reg_writes = 0;
    int n_settings = 0;

    blit_clip_calculator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Work area clipped to the canvas, bitmap clipped to the work area, 32-bit signed compares.
    function automatic bcc_pkg::bcc_res_t clip_blit(bcc_pkg::bcc_req_t r);
        int cax, cay, caw, cah, bx, by, baw, bah, cw, ch, btw, bth, imx, imy, d;
        logic [31:0] src, dst;
        logic ok;
        bcc_pkg::bcc_res_t e;
        cax = $signed(r.area_x);
        cay = $signed(r.area_y);
        caw = r.area_width;
        cah = r.area_height;
        bx  = $signed(r.image_x);
        by  = $signed(r.image_y);
        baw = r.image_width;
        bah = r.image_height;
        cw  = canvas_w;
        ch  = canvas_h;
        btw = baw;
        bth = bah;
        imx = bx;
        imy = by;
        src = '0;
        dst = '0;
        ok = !(cax > cw || cay > ch || bx + baw < cax || by + bah < cay ||
               cax + caw < bx || cay + cah < by);
        if (ok) begin
            if (cax < 0) begin
                caw = (caw + cax) & 32'hFFFF;
                cax = 0;
            end
            if (cax + caw > cw)
                caw = (caw - (cax + caw - cw)) & 32'hFFFF;
            if (cay < 0) begin
                cah = (cah + cay) & 32'hFFFF;
                cay = 0;
            end
            if (cay + cah > ch)
                cah = (cah - (cay + cah - ch)) & 32'hFFFF;

            // a bitmap trimmed at the left keeps its own x
            if (bx < cax) begin
                d = cax - bx;
                src = src + d;
                btw = (btw - d) & 32'hFFFF;
                bx = cax;
            end else begin
                imx = (bx - cax) & 32'hFFFF;
                dst = dst + bx;
            end
            if (bx + btw > cax + caw)
                btw = (btw - (btw + bx - caw - cax)) & 32'hFFFF;
            else
                caw = (caw - (caw + cax - btw - bx)) & 32'hFFFF;

            if (by < cay) begin
                d = cay - by;
                src = src + d * baw;
                bth = (bth - d) & 32'hFFFF;
                by = cay;
            end else begin
                imy = (by - cay) & 32'hFFFF;
                dst = dst + cw * by;
            end
            if (by + bth > cay + cah)
                bth = (bth - (bth + by - cah - cay)) & 32'hFFFF;
            else
                cah = (cah - (cah + cay - bth - by)) & 32'hFFFF;
        end
        e.valid_res            = ok;
        e.source_offset        = src;
        e.dest_offset          = dst;
        e.clipped_area_x       = 16'(cax);
        e.clipped_area_y       = 16'(cay);
        e.clipped_area_width   = 16'(caw);
        e.clipped_area_height  = 16'(cah);
        e.clipped_image_x      = 16'(imx);
        e.clipped_image_y      = 16'(imy);
        e.clipped_image_width  = 16'(btw);
        e.clipped_image_height = 16'(bth);
        return e;
    endfunction

    function automatic bcc_pkg::bcc_req_t blit(int ax, int ay, int aw, int ah,
                                               int ix, int iy, int iw, int ih);
        return '{16'(ax), 16'(ay), 16'(aw), 16'(ah), 16'(ix), 16'(iy), 16'(iw), 16'(ih)};
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         n_results, name, want, got);
        end
    endfunction

    // Mostly plausible requests near the canvas, some pure noise, some with one field broken.
    task automatic queue_random(int count);
        bcc_pkg::bcc_req_t r;
        logic [7:0][15:0] words;
        int span_x, span_y, ax, ay, aw, ah, roll;
        repeat (count) begin
            roll = $urandom_range(99);
            span_x = canvas_w + 16;
            span_y = canvas_h + 16;
            if (roll < 10) begin
                r = {$urandom, $urandom, $urandom, $urandom};
            end else begin
                ax = rand_between(-(span_x / 4), canvas_w);
                ay = rand_between(-(span_y / 4), canvas_h);
                aw = $urandom_range(span_x);
                ah = $urandom_range(span_y);
                r = blit(ax, ay, aw, ah,
                         ax + rand_between(-(span_x / 2), aw),
                         ay + rand_between(-(span_y / 2), ah),
                         $urandom_range(span_x), $urandom_range(span_y));
                if (roll < 22) begin
                    words = r;
                    case ($urandom_range(4))
                        0: words[$urandom_range(7)] = 16'h0000;
                        1: words[$urandom_range(7)] = 16'h7FFF;
                        2: words[$urandom_range(7)] = 16'h8000;
                        3: words[$urandom_range(7)] = 16'hFFFF;
                        default: words[$urandom_range(7)] = 16'($urandom);
                    endcase
                    r = words;
                end
            end
            blit_queue.push_back(r);
        end
    endtask

    task automatic write_canvas_reg(logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bcc_pkg::FIELD_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_reg_writes++;
        if (idx == bcc_pkg::REG_CANVAS_WIDTH)
            canvas_w = val;
        else if (idx == bcc_pkg::REG_CANVAS_HEIGHT)
            canvas_h = val;
    endtask

    task automatic set_canvas(logic [bcc_pkg::FIELD_W-1:0] w, logic [bcc_pkg::FIELD_W-1:0] h);
        write_canvas_reg(bcc_pkg::REG_CANVAS_WIDTH, w);
        write_canvas_reg(bcc_pkg::REG_CANVAS_HEIGHT, h);
        n_settings++;
    endtask

    task automatic drain();
        while (blit_queue.size() != 0 || s_tvalid || awaited_clips.size() != 0)
            @(posedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_clips.push_back(clip_blit(held_req));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (blit_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    held_req = blit_queue.pop_front();
                    s_tdata  <= {held_req.image_height, held_req.image_width,
                                 held_req.image_y, held_req.image_x,
                                 held_req.area_height, held_req.area_width,
                                 held_req.area_y, held_req.area_x};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_clips.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: tuser %b tdata %h", m_tuser, m_tdata);
            end else begin
                want_clip = awaited_clips.pop_front();
                check_field("valid_res", want_clip.valid_res, m_tuser);
                check_field("source_offset", want_clip.source_offset, m_tdata[31:0]);
                check_field("dest_offset", want_clip.dest_offset, m_tdata[63:32]);
                check_field("clipped_area_x", want_clip.clipped_area_x, m_tdata[79:64]);
                check_field("clipped_area_y", want_clip.clipped_area_y, m_tdata[95:80]);
                check_field("clipped_area_width", want_clip.clipped_area_width,
                            m_tdata[111:96]);
                check_field("clipped_area_height", want_clip.clipped_area_height,
                            m_tdata[127:112]);
                check_field("clipped_image_x", want_clip.clipped_image_x, m_tdata[143:128]);
                check_field("clipped_image_y", want_clip.clipped_image_y, m_tdata[159:144]);
                check_field("clipped_image_width", want_clip.clipped_image_width,
                            m_tdata[175:160]);
                check_field("clipped_image_height", want_clip.clipped_image_height,
                            m_tdata[191:176]);
                n_results++;
                if (want_clip.valid_res)
                    n_drawn++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, awaited_clips.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int phase_w[9] = '{1, 640, 65535, 0, 320, 65535, -1, -1, 64};
        int phase_h[9] = '{1, 480, 65535, 65535, 200, 1, -1, -1, 0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // canvas still at its reset size
        n_settings++;
        queue_random(60);
        drain();

        set_canvas(16'd640, 16'd480);
        blit_queue.push_back(blit(10, 20, 100, 50, 30, 40, 16, 8));
        blit_queue.push_back(blit(641, 0, 10, 10, 641, 0, 5, 5));        // origin past right
        blit_queue.push_back(blit(0, 481, 10, 10, 0, 481, 5, 5));        // origin past bottom
        blit_queue.push_back(blit(100, 100, 50, 50, 10, 100, 20, 20));   // bitmap left of area
        blit_queue.push_back(blit(100, 100, 50, 50, 100, 10, 20, 20));   // bitmap above area
        blit_queue.push_back(blit(100, 100, 50, 50, 200, 100, 10, 10));  // area left of bitmap
        blit_queue.push_back(blit(100, 100, 50, 50, 100, 200, 10, 10));  // area above bitmap
        blit_queue.push_back(blit(-10, -5, 100, 80, 0, 0, 30, 30));
        blit_queue.push_back(blit(600, 450, 100, 100, 610, 460, 20, 20));
        blit_queue.push_back(blit(100, 100, 50, 50, 90, 80, 30, 40));    // trimmed left and top
        blit_queue.push_back(blit(100, 100, 50, 50, 140, 140, 30, 30));
        blit_queue.push_back(blit(640, 480, 0, 0, 640, 480, 0, 0));
        blit_queue.push_back(blit(0, 0, 0, 0, 0, 0, 0, 0));
        blit_queue.push_back(blit(-1, -1, 65535, 65535, -1, -1, 65535, 65535));
        blit_queue.push_back(blit(-32768, -32768, 32768, 32768, -32768, -32768, 32768, 32768));
        blit_queue.push_back(blit(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        blit_queue.push_back(blit(-32768, -32768, 65535, 65535, -32768, -32768, 65535, 65535));
        drain();

        set_canvas(16'hFFFF, 16'hFFFF);
        blit_queue.push_back(blit(0, 0, 65535, 65535, 32767, 32767, 65535, 65535));
        blit_queue.push_back(blit(32767, 32767, 65535, 65535, -32768, -32768, 65535, 65535));
        blit_queue.push_back(blit(0, 0, 1, 1, 0, 0, 1, 1));
        blit_queue.push_back(blit(32767, 32767, 0, 0, 32767, 32767, 0, 0));
        blit_queue.push_back(blit(-1, -1, 2, 2, -1, -1, 3, 3));
        drain();

        // indexes past the last register must leave the canvas alone
        write_canvas_reg(8'd2, 16'($urandom));
        write_canvas_reg(8'd255, 16'($urandom));
        blit_queue.push_back(blit(100, 100, 50, 50, 90, 80, 30, 40));

        for (int p = 0; p < 9; p++) begin
            drain();
            set_canvas(phase_w[p] < 0 ? 16'($urandom) : 16'(phase_w[p]),
                       phase_h[p] < 0 ? 16'($urandom) : 16'(phase_h[p]));
            idle_pct = (p == 4) ? 0 : 9;
            queue_random(PHASE_ITEMS);
        end
        drain();
        repeat (8) @(posedge aclk);

        $display("covered %0d requests (%0d drawn, %0d rejected) across %0d canvas sizes",
                 n_sent, n_drawn, n_results - n_drawn, n_settings);
        $display("%0d register writes, %0d results checked, %0d mismatches",
                 n_reg_writes, n_results, errors);
        if (errors == 0 && awaited_clips.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bcc_pkg.sv
hdl/bcc_cfg_regs.sv
hdl/bcc_clip_core.sv
hdl/blit_clip_calculator_unit.sv
bench/blit_clip_calculator_unit_tb.sv
